// ----- hw/rtl/uah_pkg.sv -----
// ----------------------------------------------------------------------------
// uah_pkg
// Shared types and constants for the unique address hash set.
// ----------------------------------------------------------------------------
package uah_pkg;

    localparam int          KEY_W      = 32;
    localparam int          CFG_W      = 4;
    localparam int          SLOT_W     = 10;
    localparam int          COUNT_W    = 11;
    localparam int          PERTURB_W  = 27;
    localparam int          MAX_BITS   = 10;
    localparam int          MIN_BITS   = 3;
    localparam logic [31:0] MIX_MULT   = 32'h045d_9f3b;
    localparam int          MIX_SHIFT  = 16;
    localparam int          PROBE_SHIFT = 5;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST = 4'd10;

    typedef enum logic [1:0] {
        RES_NEW  = 2'd0,
        RES_DUP  = 2'd1,
        RES_MISS = 2'd2
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MIX2,
        ST_MUL2,
        ST_MIX3,
        ST_PROBE,
        ST_CHECK
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_MUL,
        DP_MIX,
        DP_PREP,
        DP_PROBE,
        DP_INSERT,
        DP_DUP,
        DP_MISS
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic perturb_zero;
        logic slot_empty;
        logic slot_match;
    } t_stat;

endpackage

// ----- hw/rtl/unique_address_hash_set.sv -----
// ----------------------------------------------------------------------------
// unique_address_hash_set
// Open-addressed set of 32-bit addresses with perturbation probing.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the slot memory, one slot a
// cycle (2**min(10, floor(log2(TABLE_DEPTH))) slots, 1024 by default), with
// busy high. A request is taken when start is high and busy is low. Hashing
// runs MUL1, MIX2, MUL2 and MIX3 (two registered multiplies); each probe is
// a PROBE state (one memory read) and a CHECK state (one compare). busy stays
// high until the result is out; the result strobe o_strobe pulses for one
// cycle right after busy falls and cannot be held off, and the next request
// may be taken in that same cycle. The single-port slot memory sets the probe
// rate. Write index_bits only while busy is low and no result is pending.
module unique_address_hash_set #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [uah_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [uah_pkg::KEY_W-1:0]     i_address,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [uah_pkg::SLOT_W-1:0]    o_slot,
    output logic [uah_pkg::COUNT_W-1:0]   o_filled_slots
);
    import uah_pkg::*;

    localparam int FLOOR_BITS = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int IDX_W      = (FLOOR_BITS < MAX_BITS) ? FLOOR_BITS : MAX_BITS;

    t_cmd  cmd;
    t_stat stat;

    uah_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    uah_dp #(
        .IDX_W (IDX_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_address      (i_address),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_filled_slots (o_filled_slots)
    );

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy not raised");

    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == RES_MISS) |-> (o_slot == '0))
        else $error("not-placed result with nonzero slot");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == RES_NEW) |-> (o_filled_slots != '0))
        else $error("insert reported with empty fill count");

endmodule

// ----- hw/rtl/uah_ctrl.sv -----
// ----------------------------------------------------------------------------
// uah_ctrl
// Sequencer: clearing pass, hash steps and the probe/check loop.
// ----------------------------------------------------------------------------
module uah_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  uah_pkg::t_stat i_stat,
    output uah_pkg::t_cmd  o_cmd
);
    import uah_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NOP;
        busy       = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.op = DP_MUL;
                n_state  = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.op = DP_MIX;
                n_state  = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.op = DP_MUL;
                n_state  = ST_MIX3;
            end
            ST_MIX3: begin
                o_cmd.op = DP_PREP;
                n_state  = ST_PROBE;
            end
            ST_PROBE: begin
                // perturb ran dry: out of probes
                if (i_stat.perturb_zero) begin
                    o_cmd.op = DP_MISS;
                    n_state  = ST_IDLE;
                end else begin
                    o_cmd.op = DP_PROBE;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (i_stat.slot_empty) begin
                    o_cmd.op = DP_INSERT;
                    n_state  = ST_IDLE;
                end else if (i_stat.slot_match) begin
                    o_cmd.op = DP_DUP;
                    n_state  = ST_IDLE;
                end else begin
                    n_state  = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/uah_dp.sv -----
// ----------------------------------------------------------------------------
// uah_dp
// Datapath: hash registers, probe arithmetic, slot memory, fill count,
// index_bits register and result registers.
// ----------------------------------------------------------------------------
module uah_dp #(
    parameter int IDX_W = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  uah_pkg::t_cmd                 i_cmd,
    output uah_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [uah_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [uah_pkg::KEY_W-1:0]     i_address,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [uah_pkg::SLOT_W-1:0]    o_slot,
    output logic [uah_pkg::COUNT_W-1:0]   o_filled_slots
);
    import uah_pkg::*;

    localparam int DEPTH = 1 << IDX_W;
    localparam logic [CFG_W-1:0] TOP_BITS = CFG_W'(IDX_W);
    localparam logic [CFG_W-1:0] LOW_BITS = CFG_W'(MIN_BITS);

    logic [KEY_W-1:0]     r_mem [0:DEPTH-1];
    logic [KEY_W-1:0]     r_rd_data;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     r_h;
    logic [PERTURB_W-1:0] r_perturb;
    logic [IDX_W-1:0]     r_i;
    logic [IDX_W-1:0]     r_slot;
    logic [IDX_W-1:0]     r_clr;
    logic [COUNT_W-1:0]   r_count;
    logic [CFG_W-1:0]     r_index_bits;
    logic                 r_out_valid;
    t_result              r_out_status;
    logic [IDX_W-1:0]     r_out_slot;
    logic [COUNT_W-1:0]   r_out_filled;

    logic [KEY_W-1:0]     h_mix;
    logic [CFG_W-1:0]     eff_bits;
    logic [IDX_W-1:0]     mask;
    logic [IDX_W-1:0]     n_i;
    logic [IDX_W-1:0]     n_slot;
    logic [COUNT_W-1:0]   n_count;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_addr;
    logic [KEY_W-1:0]     mem_wdata;

    assign h_mix = r_h ^ (r_h >> MIX_SHIFT);

    // clamp index_bits to the sizes the table supports
    always_comb begin
        priority if (r_index_bits < LOW_BITS) begin
            eff_bits = LOW_BITS;
        end else if (r_index_bits > TOP_BITS) begin
            eff_bits = TOP_BITS;
        end else begin
            eff_bits = r_index_bits;
        end
        for (int k = 0; k < IDX_W; k++) begin
            mask[k] = (CFG_W'(k) < eff_bits);
        end
    end

    // i = 5*i + perturb + 1; only the low index bits ever reach a slot
    assign n_i     = IDX_W'({r_i, 2'b00}) + r_i + r_perturb[IDX_W-1:0] + IDX_W'(1);
    assign n_slot  = n_i & mask;
    assign n_count = r_count + COUNT_W'(1);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = n_slot;
        mem_wdata = r_key;
        unique case (i_cmd.op)
            DP_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
            end
            DP_INSERT: begin
                mem_we    = 1'b1;
                mem_addr  = r_slot;
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_key <= i_address;
                r_h   <= i_address ^ (i_address >> MIX_SHIFT);
            end
            DP_MUL: begin
                r_h <= r_h * MIX_MULT;
            end
            DP_MIX: begin
                r_h <= h_mix;
            end
            DP_PREP: begin
                r_perturb <= PERTURB_W'(h_mix >> PROBE_SHIFT);
                r_i       <= '0;
            end
            DP_PROBE: begin
                r_perturb <= r_perturb >> PROBE_SHIFT;
                r_i       <= n_i;
                r_slot    <= n_slot;
            end
            default: begin
                r_h <= r_h;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_count      <= '0;
            r_index_bits <= INDEX_BITS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == DP_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cmd.op == DP_INSERT) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_index_bits <= i_cfg_wdata;
            end
            r_out_valid <= (i_cmd.op == DP_INSERT) || (i_cmd.op == DP_DUP) ||
                           (i_cmd.op == DP_MISS);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_INSERT: begin
                r_out_status <= RES_NEW;
                r_out_slot   <= r_slot;
                r_out_filled <= n_count;
            end
            DP_DUP: begin
                r_out_status <= RES_DUP;
                r_out_slot   <= r_slot;
                r_out_filled <= r_count;
            end
            DP_MISS: begin
                r_out_status <= RES_MISS;
                r_out_slot   <= '0;
                r_out_filled <= r_count;
            end
            default: begin
                r_out_status <= r_out_status;
            end
        endcase
    end

    assign o_stat.clear_last   = (r_clr == {IDX_W{1'b1}});
    assign o_stat.perturb_zero = (r_perturb == '0);
    assign o_stat.slot_empty   = (r_rd_data == '0);
    assign o_stat.slot_match   = (r_rd_data == r_key);

    assign o_strobe       = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = SLOT_W'(r_out_slot);
    assign o_filled_slots = r_out_filled;

endmodule
